### design/tilt_to_differential_drive_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tilt to differential drive block
// Concurrent checks sampled on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef TILT_TO_DIFFERENTIAL_DRIVE_DEFINES_SVH
`define TILT_TO_DIFFERENTIAL_DRIVE_DEFINES_SVH

// Checks a property on every rising edge of clk outside reset.
`define TDD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks an implication on every rising edge of clk outside reset.
`define TDD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

### design/tdd_pkg.sv
// ----------------------------------------------------------------------------
// tdd_pkg
// Types, constants and helpers shared by the tilt to differential drive block.
// ----------------------------------------------------------------------------
package tdd_pkg;

  localparam logic [15:0] Q_ONE = 16'd32768;
  localparam logic [15:0] Q_HALF = 16'd16384;
  localparam logic signed [15:0] TILT_LIMIT = 16'sd160;

  localparam logic [15:0] FWD_SCALE_RESET = 16'd22938;
  localparam logic [15:0] REVERSE_SPEED_RESET = 16'd26214;
  localparam logic [15:0] REVERSE_THRESHOLD_RESET = 16'd3277;

  typedef enum logic [1:0] {
    REG_FWD_SCALE         = 2'd0,
    REG_REVERSE_SPEED     = 2'd1,
    REG_REVERSE_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] tilt_x;
    logic signed [15:0] tilt_y;
  } tilt_t;

  typedef struct packed {
    logic [15:0] left_drive;
    logic [15:0] right_drive;
    logic        reversing;
  } drive_t;

  // Mapped fractions after the first stage.
  typedef struct packed {
    logic [15:0] y;
    logic [15:0] mag_x;
    logic        x_pos;
  } map_t;

  // Final speed and wheel ratios ahead of the drive multipliers.
  typedef struct packed {
    logic [15:0] speed;
    logic [15:0] left_ratio;
    logic [15:0] right_ratio;
    logic        reversing;
  } speed_t;

  // Configuration values seen by the datapath.
  typedef struct packed {
    logic [15:0] fwd_scale;
    logic [15:0] reverse_speed;
    logic [15:0] reverse_threshold;
  } cfg_t;

  function automatic logic [15:0] cap_one(input logic [15:0] v);
    return (v > Q_ONE) ? Q_ONE : v;
  endfunction

endpackage

### design/tdd_map.sv
// ----------------------------------------------------------------------------
// tdd_map
// Clamps both tilt axes and maps them to Q1.15 steering and throttle fractions.
// ----------------------------------------------------------------------------
module tdd_map
  import tdd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_ready,
  input  tilt_t up_data,
  output logic  dn_valid,
  input  logic  dn_ready,
  output map_t  dn_data
);

  logic signed [15:0] tx;
  logic signed [15:0] ty;
  logic signed [8:0]  xc;
  logic signed [8:0]  yc;
  logic [7:0]         ax;
  logic [8:0]         uy;
  logic [17:0]        ax_w;
  logic [17:0]        uy_w;
  logic [17:0]        mag_full;
  logic [17:0]        y_full;
  map_t               map_next;
  logic               valid;
  map_t               data;

  always_comb begin
    tx = up_data.tilt_x;
    ty = up_data.tilt_y;
    if (tx > TILT_LIMIT) begin
      xc = TILT_LIMIT[8:0];
    end else if (tx < -TILT_LIMIT) begin
      xc = -TILT_LIMIT[8:0];
    end else begin
      xc = tx[8:0];
    end
    if (ty > TILT_LIMIT) begin
      yc = TILT_LIMIT[8:0];
    end else if (ty < -TILT_LIMIT) begin
      yc = -TILT_LIMIT[8:0];
    end else begin
      yc = ty[8:0];
    end
    ax = xc[8] ? 8'(-xc) : xc[7:0];
    uy = 9'(yc + TILT_LIMIT[8:0]);
    ax_w = {10'd0, ax};
    uy_w = {9'd0, uy};
    // Division by five as a whole part plus a small reciprocal correction:
    // n*1024/5 = n*204 + (4n)/5 and n*512/5 = n*102 + (2n)/5.
    mag_full = ax_w * 18'd204 + ((ax_w * 18'd820) >> 10);
    y_full = uy_w * 18'd102 + ((uy_w * 18'd410) >> 10);
    map_next.mag_x = mag_full[15:0];
    map_next.y = y_full[15:0];
    map_next.x_pos = !xc[8] && (xc != 9'sd0);
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= map_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data = data;

endmodule

### design/tdd_speed.sv
// ----------------------------------------------------------------------------
// tdd_speed
// Three stages: throttle products, speed curve, reverse choice and ratios.
// ----------------------------------------------------------------------------
module tdd_speed
  import tdd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   up_valid,
  output logic   up_ready,
  input  map_t   up_data,
  output logic   dn_valid,
  input  logic   dn_ready,
  output speed_t dn_data
);

  // Stage A: squares and the high branch product.
  logic        a_valid;
  logic        a_ready;
  logic [27:0] a_sq;
  logic [31:0] a_hp;
  logic        a_low;
  logic [15:0] a_mag_x;
  logic        a_x_pos;

  // Stage B: both branch speeds.
  logic        b_valid;
  logic        b_ready;
  logic [28:0] b_prod;
  logic [15:0] b_hi_speed;
  logic        b_low;
  logic [15:0] b_mag_x;
  logic        b_x_pos;

  // Stage C: selected speed and ratios.
  logic        c_valid;
  speed_t      c_data;

  logic [27:0] sq_next;
  logic [31:0] hp_next;
  logic [28:0] prod_next;
  logic [15:0] hi_speed_next;
  speed_t      c_next;
  logic [15:0] lo_speed;
  logic [15:0] speed_raw;
  logic [15:0] adj_ratio;
  logic        rev;

  assign up_ready = !a_valid || a_ready;
  assign a_ready = !b_valid || b_ready;
  assign b_ready = !c_valid || dn_ready;

  always_comb begin
    sq_next = {14'd0, up_data.y[13:0]} * {14'd0, up_data.y[13:0]};
    hp_next = {16'd0, 16'(Q_ONE - cfg.fwd_scale)} * {16'd0, 16'(Q_ONE - up_data.y)};
  end

  always_comb begin
    prod_next = {13'd0, cfg.fwd_scale} * {16'd0, a_sq[27:15]};
    hi_speed_next = 16'(Q_ONE - a_hp[29:14]);
  end

  always_comb begin
    lo_speed = b_prod[28:13];
    speed_raw = b_low ? lo_speed : b_hi_speed;
    rev = speed_raw < cfg.reverse_threshold;
    adj_ratio = 16'(Q_ONE - b_mag_x);
    c_next.speed = rev ? cfg.reverse_speed : speed_raw;
    c_next.reversing = rev;
    c_next.left_ratio = b_x_pos ? Q_ONE : adj_ratio;
    c_next.right_ratio = b_x_pos ? adj_ratio : Q_ONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (up_ready) begin
        a_valid <= up_valid;
      end
      if (a_ready) begin
        b_valid <= a_valid;
      end
      if (b_ready) begin
        c_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      a_sq <= sq_next;
      a_hp <= hp_next;
      a_low <= (up_data.y < Q_HALF);
      a_mag_x <= up_data.mag_x;
      a_x_pos <= up_data.x_pos;
    end
    if (a_ready && a_valid) begin
      b_prod <= prod_next;
      b_hi_speed <= hi_speed_next;
      b_low <= a_low;
      b_mag_x <= a_mag_x;
      b_x_pos <= a_x_pos;
    end
    if (b_ready && b_valid) begin
      c_data <= c_next;
    end
  end

  assign dn_valid = c_valid;
  assign dn_data = c_data;

endmodule

### design/tdd_drive.sv
// ----------------------------------------------------------------------------
// tdd_drive
// Scales the speed by each wheel ratio and holds the result for the output.
// ----------------------------------------------------------------------------
module tdd_drive
  import tdd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   up_valid,
  output logic   up_ready,
  input  speed_t up_data,
  output logic   dn_valid,
  input  logic   dn_stall,
  output drive_t dn_data
);

  logic [31:0] left_prod;
  logic [31:0] right_prod;
  drive_t      drive_next;
  logic        valid;
  drive_t      data;

  always_comb begin
    left_prod = {16'd0, up_data.speed} * {16'd0, up_data.left_ratio};
    right_prod = {16'd0, up_data.speed} * {16'd0, up_data.right_ratio};
    drive_next.left_drive = left_prod[30:15];
    drive_next.right_drive = right_prod[30:15];
    drive_next.reversing = up_data.reversing;
  end

  assign up_ready = !valid || !dn_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= drive_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data = data;

endmodule

### design/tilt_to_differential_drive.sv
// ----------------------------------------------------------------------------
// tilt_to_differential_drive
// Maps an X/Y tilt item to left and right wheel drive and a reverse flag.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while drive_stall is low.
// Each of the five register stages holds one item: map, speed A, B, C, drive.
// A stage that is empty or moving on takes the next item, so bubbles close up.
// Reset clears every stage's valid bit and loads the default register values.
// ----------------------------------------------------------------------------
`include "tilt_to_differential_drive_defines.svh"

module tilt_to_differential_drive
  import tdd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        tilt_valid,
  output logic        tilt_stall,
  input  tilt_t       tilt,
  output logic        drive_valid,
  input  logic        drive_stall,
  output drive_t      drive,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t   cfg;
  logic   tilt_ready;
  logic   map_valid;
  logic   map_ready;
  map_t   map_data;
  logic   speed_valid;
  logic   speed_ready;
  speed_t speed_data;

  // Speed registers are stored already capped at one.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fwd_scale <= FWD_SCALE_RESET;
      cfg.reverse_speed <= REVERSE_SPEED_RESET;
      cfg.reverse_threshold <= REVERSE_THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FWD_SCALE: begin
          cfg.fwd_scale <= cap_one(cfg_data);
        end
        REG_REVERSE_SPEED: begin
          cfg.reverse_speed <= cap_one(cfg_data);
        end
        REG_REVERSE_THRESHOLD: begin
          cfg.reverse_threshold <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  tdd_map u_map (
    .clk      (clk),
    .rst      (rst),
    .up_valid (tilt_valid),
    .up_ready (tilt_ready),
    .up_data  (tilt),
    .dn_valid (map_valid),
    .dn_ready (map_ready),
    .dn_data  (map_data)
  );

  tdd_speed u_speed (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (map_valid),
    .up_ready (map_ready),
    .up_data  (map_data),
    .dn_valid (speed_valid),
    .dn_ready (speed_ready),
    .dn_data  (speed_data)
  );

  tdd_drive u_drive (
    .clk      (clk),
    .rst      (rst),
    .up_valid (speed_valid),
    .up_ready (speed_ready),
    .up_data  (speed_data),
    .dn_valid (drive_valid),
    .dn_stall (drive_stall),
    .dn_data  (drive)
  );

  assign tilt_stall = !tilt_ready;

  // An output that is free to move means every stage can move.
  `TDD_ASSERT_IMP(a_no_stall_when_free, !drive_stall, !tilt_stall,
                  "input stalled while the output is free")
  // One wheel always runs at the full speed, which is the reverse speed here.
  `TDD_ASSERT_IMP(a_reverse_speed, drive_valid && drive.reversing,
                  drive.left_drive == cfg.reverse_speed ||
                  drive.right_drive == cfg.reverse_speed,
                  "reversing item without a wheel at reverse speed")
  // No drive value may exceed one.
  `TDD_ASSERT_IMP(a_drive_range, drive_valid,
                  drive.left_drive <= Q_ONE && drive.right_drive <= Q_ONE,
                  "drive value above one")

endmodule

### verif/tdd_drive_checker.sv
// ----------------------------------------------------------------------------
// tdd_drive_checker
// Watches the tilt, drive and register ports of the drive block. For each
// accepted tilt item it computes the expected wheel drive, and it compares
// every accepted drive item with the oldest expected one.
// ----------------------------------------------------------------------------
module tdd_drive_checker
  import tdd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        tilt_valid,
  input  logic        tilt_stall,
  input  tilt_t       tilt,
  input  logic        drive_valid,
  input  logic        drive_stall,
  input  drive_t      drive,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int unsigned fail_count,
  output int unsigned pending
);

  localparam int unsigned UNIT = 32'(Q_ONE);
  localparam int TILT_MAX = int'(TILT_LIMIT);

  logic [15:0] dflt_speed;
  logic [15:0] rev_speed;
  logic [15:0] rev_thresh;
  drive_t      expected_drive_q[$];
  int unsigned fails;

  function automatic int limit_tilt(input logic signed [15:0] v);
    int w;
    w = v;
    if (w > TILT_MAX) return TILT_MAX;
    if (w < -TILT_MAX) return -TILT_MAX;
    return w;
  endfunction

  function automatic int unsigned saturate_unit(input logic [15:0] v);
    return (32'(v) > UNIT) ? UNIT : 32'(v);
  endfunction

  function automatic drive_t predict_drive(input tilt_t t);
    int          xc;
    int          yc;
    int unsigned ax;
    int unsigned mag_x;
    int unsigned y;
    int unsigned d;
    int unsigned spd;
    int unsigned left_ratio;
    int unsigned right_ratio;
    drive_t      r;
    xc = limit_tilt(t.tilt_x);
    yc = limit_tilt(t.tilt_y);
    ax = (xc < 0) ? -xc : xc;
    mag_x = (ax * 1024) / 5;
    y = ((yc + TILT_MAX) * 512) / 5;
    d = saturate_unit(dflt_speed);
    if (y < UNIT / 2) begin
      spd = (d * ((y * y) >> 15)) >> 13;
    end else begin
      spd = UNIT - (((UNIT - d) * (UNIT - y)) >> 14);
    end
    r.reversing = 1'b0;
    // The threshold is compared as written, so values above one always reverse.
    if (spd < 32'(rev_thresh)) begin
      spd = saturate_unit(rev_speed);
      r.reversing = 1'b1;
    end
    left_ratio = UNIT;
    right_ratio = UNIT;
    if (xc > 0) begin
      right_ratio = UNIT - mag_x;
    end else begin
      left_ratio = UNIT - mag_x;
    end
    r.left_drive = 16'((spd * left_ratio) >> 15);
    r.right_drive = 16'((spd * right_ratio) >> 15);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    drive_t want;
    if (rst) begin
      dflt_speed = FWD_SCALE_RESET;
      rev_speed = REVERSE_SPEED_RESET;
      rev_thresh = REVERSE_THRESHOLD_RESET;
      expected_drive_q.delete();
      fails = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FWD_SCALE:         dflt_speed = cfg_data;
          REG_REVERSE_SPEED:     rev_speed = cfg_data;
          REG_REVERSE_THRESHOLD: rev_thresh = cfg_data;
          default: ;
        endcase
      end
      if (drive_valid && !drive_stall) begin
        if (expected_drive_q.size() == 0) begin
          $error("drive item accepted with no tilt item outstanding");
          fails++;
        end else begin
          want = expected_drive_q.pop_front();
          if (drive.left_drive !== want.left_drive) begin
            $error("left_drive: expected %0d, got %0d", want.left_drive, drive.left_drive);
            fails++;
          end
          if (drive.right_drive !== want.right_drive) begin
            $error("right_drive: expected %0d, got %0d", want.right_drive, drive.right_drive);
            fails++;
          end
          if (drive.reversing !== want.reversing) begin
            $error("reversing: expected %0b, got %0b", want.reversing, drive.reversing);
            fails++;
          end
        end
      end
      if (tilt_valid && !tilt_stall) begin
        expected_drive_q.push_back(predict_drive(tilt));
      end
    end
    fail_count <= fails;
    pending <= expected_drive_q.size();
  end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives tilt items and register settings into the drive block, with random
// gaps on the sender and random stalls on the receiver, and gives the verdict
// from the failure and pending counts that the checker reports.
// ----------------------------------------------------------------------------
module tb_top;
  import tdd_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int PHASES = 7;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int DIRECTED_ITEMS = 22;
  localparam logic [1:0] REG_UNUSED_INDEX = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        tilt_valid = 1'b0;
  logic        tilt_stall;
  tilt_t       tilt = '0;
  logic        drive_valid;
  logic        drive_stall = 1'b0;
  drive_t      drive;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned cycle_count = 0;

  int dir_x[DIRECTED_ITEMS] = '{0, 32767, -32768, 32767, -32768, 160, -160, 161, -161,
                                159, 1, -1, 0, 80, -80, 0, 0, 0, 0, 0, 85, 21845};
  int dir_y[DIRECTED_ITEMS] = '{0, 32767, -32768, -32768, 32767, 160, -160, -161, 161,
                                -159, 0, 0, -1, -80, 80, -160, -150, -130, -100, 160, -1,
                                -21846};
  int tilt_edges[9] = '{-161, -160, -159, -1, 0, 1, 159, 160, 161};

  always #4 clk = ~clk;

  tilt_to_differential_drive dut (
    .clk         (clk),
    .rst         (rst),
    .tilt_valid  (tilt_valid),
    .tilt_stall  (tilt_stall),
    .tilt        (tilt),
    .drive_valid (drive_valid),
    .drive_stall (drive_stall),
    .drive       (drive),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  tdd_drive_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .tilt_valid  (tilt_valid),
    .tilt_stall  (tilt_stall),
    .tilt        (tilt),
    .drive_valid (drive_valid),
    .drive_stall (drive_stall),
    .drive       (drive),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // Receiver: random stalls, or a long hold-off when one has been asked for.
  initial begin : receiver
    int unsigned held;
    held = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        drive_stall <= 1'b0;
      end else if (holds_done != holds_asked) begin
        drive_stall <= 1'b1;
        held++;
        if (held == HOLD_CYCLES) begin
          held = 0;
          holds_done++;
        end
      end else begin
        drive_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tilt_to_differential_drive test failed");
    $finish;
  end

  // Offers one tilt item and returns at the edge where it is accepted.
  task automatic send_tilt(input logic signed [15:0] x, input logic signed [15:0] y);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      tilt_valid <= 1'b0;
      @(posedge clk);
    end
    tilt_valid <= 1'b1;
    tilt <= '{tilt_x: x, tilt_y: y};
    @(posedge clk);
    while (tilt_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    tilt_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic program_regs(input logic [15:0] dflt, input logic [15:0] rev,
                              input logic [15:0] thr, input bit poke_unused);
    cfg_we <= 1'b1;
    cfg_index <= REG_FWD_SCALE;
    cfg_data <= dflt;
    @(posedge clk);
    cfg_index <= REG_REVERSE_SPEED;
    cfg_data <= rev;
    @(posedge clk);
    cfg_index <= REG_REVERSE_THRESHOLD;
    cfg_data <= thr;
    @(posedge clk);
    if (poke_unused) begin
      // An unknown index must leave every register alone.
      cfg_index <= REG_UNUSED_INDEX;
      cfg_data <= 16'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly counts near the clamp range, where the mapping does its work.
  function automatic logic signed [15:0] pick_tilt();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return 16'($urandom_range(340) - 170);
    if (roll < 85) return 16'($urandom);
    return 16'(tilt_edges[$urandom_range(8)]);
  endfunction

  initial begin : stimulus
    int phase;
    int n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items with the reset register values.
    for (n = 0; n < DIRECTED_ITEMS; n++) begin
      send_tilt(16'(dir_x[n]), 16'(dir_y[n]));
    end
    wait_drained();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          program_regs(Q_ONE, Q_ONE, 16'd0, 1'b0);
          send_idle_pct = 46;
          recv_stall_pct = 0;
        end
        2: begin
          program_regs(16'd0, 16'd0, Q_ONE, 1'b0);
          send_idle_pct = 0;
          recv_stall_pct = 46;
        end
        3: begin
          program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
          send_idle_pct = 21;
          recv_stall_pct = 21;
        end
        4: begin
          program_regs(16'($urandom_range(32768)), 16'($urandom_range(32768)),
                       16'($urandom_range(12000)), 1'b1);
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        5: begin
          program_regs(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
          send_idle_pct = 46;
          recv_stall_pct = 46;
        end
        default: begin
          program_regs(FWD_SCALE_RESET, REVERSE_SPEED_RESET,
                       REVERSE_THRESHOLD_RESET, 1'b0);
          send_idle_pct = 21;
          recv_stall_pct = 21;
        end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 4 && n == 40) begin
          // The receiver holds off while items keep coming, so the pipeline fills.
          holds_asked++;
        end
        if (phase == 1 && n == ITEMS_PER_PHASE / 2) begin
          wait_drained();
        end
        send_tilt(pick_tilt(), pick_tilt());
      end
      wait_drained();
    end

    recv_stall_pct = 0;
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tilt_to_differential_drive test passed");
    end else begin
      $display("tilt_to_differential_drive test failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/tdd_pkg.sv
design/tdd_map.sv
design/tdd_speed.sv
design/tdd_drive.sv
design/tilt_to_differential_drive.sv
verif/tdd_drive_checker.sv
verif/tb_top.sv
